// ===== hw/rtl/mandelbrot_escape_time_macros.svh =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time assertion macros
// Shared concurrent assertion helpers for the escape-time unit.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define MBE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time package
// Types, register map and fixed-point helpers shared by the unit's modules.
// ----------------------------------------------------------------------------
package mbe_pkg;

   // Q4.28 fraction bits; escape when |z|^2 reaches 4.0 in Q8.56
   localparam int FRAC_BITS = 28;
   localparam int ESC_BIT   = 2 * FRAC_BITS + 2;

   // Register reset values
   localparam logic [31:0] LEFT_RESET     = 32'hE000_0000;
   localparam logic [31:0] BOTTOM_RESET   = 32'hE000_0000;
   localparam logic [30:0] STEP_X_RESET   = 31'h0010_0000;
   localparam logic [30:0] STEP_Y_RESET   = 31'h0010_0000;
   localparam logic [15:0] MAX_ITER_RESET = 16'd1000;

   // Register index, taken from paddr[4:2]
   typedef enum logic [2:0] {
      REG_LEFT     = 3'd0,
      REG_BOTTOM   = 3'd1,
      REG_STEP_X   = 3'd2,
      REG_STEP_Y   = 3'd3,
      REG_MAX_ITER = 3'd4
   } reg_idx_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [31:0] left_edge;
      logic [31:0] bottom_edge;
      logic [30:0] step_x;
      logic [30:0] step_y;
      logic [15:0] max_iter;
   } cfg_type;

   // Operand pair fed to the shared multiplier
   typedef enum logic [2:0] {
      MOP_COL_X = 3'd0,
      MOP_ROW_Y = 3'd1,
      MOP_A_A   = 3'd2,
      MOP_B_B   = 3'd3,
      MOP_A_B   = 3'd4
   } mul_op_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       mul_en;
      mul_op_type mul_op;
      logic       cr_we;
      logic       ci_we;
      logic       aa_we;
      logic       test_we;
      logic       upd_we;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic zero_limit;
      logic last_iter;
      logic escaped;
   } dp_status_type;

   // Saturate a 64-bit signed value to the Q4.28 range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/mbe_csr.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time register file
// APB-style write/read access to the frame and iteration-limit registers.
// ----------------------------------------------------------------------------
module mbe_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output mbe_pkg::cfg_type      cfg
);

   logic [31:0] left_ff,   left_in;
   logic [31:0] bottom_ff, bottom_in;
   logic [30:0] step_x_ff, step_x_in;
   logic [30:0] step_y_ff, step_y_in;
   logic [15:0] max_iter_ff, max_iter_in;
   logic [2:0]  idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = paddr[4:2];
   assign wr_en  = psel & penable & pwrite;

   // Decode the write transfer
   always_comb begin
      left_in     = left_ff;
      bottom_in   = bottom_ff;
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      max_iter_in = max_iter_ff;
      if (wr_en) begin
         unique case (idx)
            mbe_pkg::REG_LEFT:     left_in     = pwdata;
            mbe_pkg::REG_BOTTOM:   bottom_in   = pwdata;
            mbe_pkg::REG_STEP_X:   step_x_in   = pwdata[30:0];
            mbe_pkg::REG_STEP_Y:   step_y_in   = pwdata[30:0];
            mbe_pkg::REG_MAX_ITER: max_iter_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff     <= mbe_pkg::LEFT_RESET;
         bottom_ff   <= mbe_pkg::BOTTOM_RESET;
         step_x_ff   <= mbe_pkg::STEP_X_RESET;
         step_y_ff   <= mbe_pkg::STEP_Y_RESET;
         max_iter_ff <= mbe_pkg::MAX_ITER_RESET;
      end else begin
         left_ff     <= left_in;
         bottom_ff   <= bottom_in;
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         max_iter_ff <= max_iter_in;
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (idx)
         mbe_pkg::REG_LEFT:     prdata = left_ff;
         mbe_pkg::REG_BOTTOM:   prdata = bottom_ff;
         mbe_pkg::REG_STEP_X:   prdata = {1'b0, step_x_ff};
         mbe_pkg::REG_STEP_Y:   prdata = {1'b0, step_y_ff};
         mbe_pkg::REG_MAX_ITER: prdata = {16'd0, max_iter_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.left_edge   = left_ff;
   assign cfg.bottom_edge = bottom_ff;
   assign cfg.step_x      = step_x_ff;
   assign cfg.step_y      = step_y_ff;
   assign cfg.max_iter    = max_iter_ff;

endmodule

// ===== hw/rtl/mbe_dp.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Shared 32x32 multiplier, point registers, escape test and z update.
// ----------------------------------------------------------------------------
module mbe_dp #(
   parameter int MAX_COLS = 4096,
   parameter int MAX_ROWS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [11:0]            req_col,
   input  logic [11:0]            req_row,
   input  mbe_pkg::cfg_type       cfg,
   input  mbe_pkg::dp_cmd_type    cmd,
   output mbe_pkg::dp_status_type status,
   output logic [15:0]            iterations
);

   localparam logic [16:0] COL_LIM = 17'(MAX_COLS);
   localparam logic [16:0] ROW_LIM = 17'(MAX_ROWS);

   logic [11:0]        col_ff, row_ff, col_in, row_in;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] cr_ff, ci_ff;
   logic signed [63:0] aa_ff, diff_ff;
   logic signed [31:0] a_ff, b_ff;
   logic [15:0]        count_ff;
   logic               esc_ff;
   logic [63:0]        mag;
   logic signed [63:0] re_sum, im_sum, cr_sum, ci_sum;

   // Clamp indices to the frame
   assign col_in = ({5'd0, req_col} >= COL_LIM) ? 12'(MAX_COLS - 1) : req_col;
   assign row_in = ({5'd0, req_row} >= ROW_LIM) ? 12'(MAX_ROWS - 1) : req_row;

   // Select multiplier operands
   always_comb begin
      unique case (cmd.mul_op)
         mbe_pkg::MOP_COL_X: begin
            mul_a = $signed({20'd0, col_ff});
            mul_b = $signed({1'b0, cfg.step_x});
         end
         mbe_pkg::MOP_ROW_Y: begin
            mul_a = $signed({20'd0, row_ff});
            mul_b = $signed({1'b0, cfg.step_y});
         end
         mbe_pkg::MOP_A_A: begin
            mul_a = a_ff;
            mul_b = a_ff;
         end
         mbe_pkg::MOP_B_B: begin
            mul_a = b_ff;
            mul_b = b_ff;
         end
         mbe_pkg::MOP_A_B: begin
            mul_a = a_ff;
            mul_b = b_ff;
         end
         default: begin
            mul_a = 32'sd0;
            mul_b = 32'sd0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Coordinate sums, magnitude and updated z
   assign cr_sum = $signed(cfg.left_edge) + prod_ff;
   assign ci_sum = $signed(cfg.bottom_edge) + prod_ff;
   assign mag    = aa_ff + prod_ff;
   assign re_sum = (diff_ff >>> mbe_pkg::FRAC_BITS) + cr_ff;
   assign im_sum = (prod_ff >>> (mbe_pkg::FRAC_BITS - 1)) + ci_ff;

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= col_in;
         row_ff <= row_in;
         a_ff   <= 32'sd0;
         b_ff   <= 32'sd0;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.cr_we) begin
         cr_ff <= mbe_pkg::sat32(cr_sum);
      end
      if (cmd.ci_we) begin
         ci_ff <= mbe_pkg::sat32(ci_sum);
      end
      if (cmd.aa_we) begin
         aa_ff <= prod_ff;
      end
      if (cmd.test_we) begin
         diff_ff <= aa_ff - prod_ff;
      end
      if (cmd.upd_we) begin
         a_ff <= mbe_pkg::sat32(re_sum);
         b_ff <= mbe_pkg::sat32(im_sum);
      end
   end

   // Iteration count and escape flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 16'd0;
         esc_ff   <= 1'b0;
      end else begin
         if (cmd.load) begin
            count_ff <= 16'd0;
         end else if (cmd.upd_we) begin
            count_ff <= count_ff + 16'd1;
         end
         if (cmd.test_we) begin
            esc_ff <= |mag[63:mbe_pkg::ESC_BIT];
         end
      end
   end

   assign status.zero_limit = (cfg.max_iter == 16'd0);
   assign status.last_iter  = (({1'b0, count_ff} + 17'd1) >= {1'b0, cfg.max_iter});
   assign status.escaped    = esc_ff;
   assign iterations        = count_ff;

endmodule

// ===== hw/rtl/mbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences point setup and the iteration loop (AA, BB, AB, UPD) over the datapath.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_macros.svh"

module mbe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output mbe_pkg::dp_cmd_type    cmd,
   input  mbe_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP_R,
      S_SETUP_I,
      S_SETUP_C,
      S_AA,
      S_BB,
      S_AB,
      S_UPD
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      strobe_ff;

   // State and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_SETUP_R;
                  busy_ff  <= 1'b1;
               end
            end
            S_SETUP_R: state_ff <= S_SETUP_I;
            S_SETUP_I: state_ff <= S_SETUP_C;
            S_SETUP_C: begin
               if (status.zero_limit) begin
                  state_ff  <= S_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end else begin
                  state_ff <= S_AA;
               end
            end
            S_AA: state_ff <= S_BB;
            S_BB: state_ff <= S_AB;
            S_AB: state_ff <= S_UPD;
            S_UPD: begin
               if (status.escaped || status.last_iter) begin
                  state_ff  <= S_IDLE;
                  busy_ff   <= 1'b0;
                  strobe_ff <= 1'b1;
               end else begin
                  state_ff <= S_AA;
               end
            end
         endcase
      end
   end

   // Decode datapath commands from the state
   always_comb begin
      cmd = '0;
      cmd.mul_op = mbe_pkg::MOP_COL_X;
      unique case (state_ff)
         S_IDLE: cmd.load = start;
         S_SETUP_R: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mbe_pkg::MOP_COL_X;
         end
         S_SETUP_I: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mbe_pkg::MOP_ROW_Y;
            cmd.cr_we  = 1'b1;
         end
         S_SETUP_C: cmd.ci_we = 1'b1;
         S_AA: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mbe_pkg::MOP_A_A;
         end
         S_BB: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = mbe_pkg::MOP_B_B;
            cmd.aa_we  = 1'b1;
         end
         S_AB: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_op  = mbe_pkg::MOP_A_B;
            cmd.test_we = 1'b1;
         end
         S_UPD: cmd.upd_we = !status.escaped;
      endcase
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

   // Controller checks
   `MBE_ASSERT_SAME(a_strobe_idle, clock, reset, strobe_ff, !busy_ff, "result strobe while busy")
   `MBE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy_ff, busy_ff, "accept did not set busy")
   `MBE_ASSERT_SAME(a_strobe_src, clock, reset, strobe_ff, $past(state_ff == S_SETUP_C) || $past(state_ff == S_UPD), "strobe without finish")
   `MBE_ASSERT_SAME(a_busy_state, clock, reset, busy_ff, state_ff != S_IDLE, "busy and state disagree")

endmodule

// ===== hw/rtl/mandelbrot_escape_time.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit
// Per-pixel escape count of z = z^2 + c in signed Q4.28 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Program left_edge, bottom_edge, step_x, step_y and max_iter over the
//   APB-style port (byte addresses 0, 4, 8, 12, 16) while the unit is idle.
//   Issue a pixel by raising start with req_col/req_row; it is taken at an
//   edge where start is high and busy is low. busy stays high while the
//   pixel is processed.
//   The count appears on rsp_iterations when rsp_strobe pulses for exactly one
//   cycle; the receiver cannot stall, so it must take it then.
//   A zero limit finishes the pixel after setup with no iteration; otherwise
//   the loop runs until the count n reaches max_iter or the point escapes
//   after n iterations; a new pixel may be issued in the strobe cycle. The rate
//   is set by the single shared 32x32 multiplier: each iteration forms
//   a*a, b*b and a*b in turn, then updates z.
//   Reset is synchronous: the unit returns to idle and the registers take
//   their reset values (frame from -2.0, step 1/256, limit 1000).
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
   parameter int MAX_COLS = 4096,
   parameter int MAX_ROWS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_col,
   input  logic [11:0] req_row,
   output logic        rsp_strobe,
   output logic [15:0] rsp_iterations,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   mbe_pkg::cfg_type       cfg;
   mbe_pkg::dp_cmd_type    cmd;
   mbe_pkg::dp_status_type status;

   // Register file
   mbe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer
   mbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // Arithmetic
   mbe_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_col    (req_col),
      .req_row    (req_row),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .iterations (rsp_iterations)
   );

endmodule

// ===== sim/mandelbrot_escape_time_test.sv =====
// ----------------------------------------------------------------------------
// Mandelbrot escape-time unit testbench
// Drives pixels into the unit under several viewports and iteration limits,
// predicts each escape count with a Q4.28 model of its own and compares
// every strobed count against the oldest prediction.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS = 4096;
   localparam int ROWS = 4096;
   localparam int FRAC = 28;
   localparam longint unsigned ESCAPE_MAG = 64'd1 << (2 * FRAC + 2);
   localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] REG_UNUSED_LAST  = 3'd7;
   localparam int PHASES     = 12;
   localparam int PHASE_PIX  = 80;
   localparam int QUIET_PASS = 3;

   typedef struct packed {
      logic [11:0] col;
      logic [11:0] row;
   } pixel_type;

   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        start   = 1'b0;
   logic        busy;
   logic [11:0] req_col = '0;
   logic [11:0] req_row = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_iterations;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [4:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   // Pixels waiting to be issued, counts waiting to come back
   pixel_type        pixel_q[$];
   logic [15:0]      count_q[$];
   pixel_type        next_px;
   logic [15:0]      want_count;
   mbe_pkg::cfg_type view;
   bit               quiet = 1'b0;
   int               errors = 0;

   mandelbrot_escape_time u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_strobe     (rsp_strobe),
      .rsp_iterations (rsp_iterations),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Clip to the signed Q4.28 range
   function automatic longint clip_q428(input longint v);
      longint r;
      if (v > 64'sd2147483647) begin
         r = 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         r = -64'sd2147483648;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Escape count of one pixel under the current viewport
   function automatic logic [15:0] escape_count(input logic [11:0] col, input logic [11:0] row);
      int unsigned px, py, n;
      longint c_re, c_im, za, zb, sq_a, sq_b, prod_ab;
      longint unsigned mag;
      px = (col >= COLS) ? COLS - 1 : col;
      py = (row >= ROWS) ? ROWS - 1 : row;
      c_re = clip_q428(longint'($signed(view.left_edge))
                       + longint'(px) * longint'(view.step_x));
      c_im = clip_q428(longint'($signed(view.bottom_edge))
                       + longint'(py) * longint'(view.step_y));
      za = 0;
      zb = 0;
      n = 0;
      while (n < view.max_iter) begin
         sq_a    = za * za;
         sq_b    = zb * zb;
         prod_ab = za * zb;
         mag     = sq_a + sq_b;
         if (mag >= ESCAPE_MAG) break;
         za = clip_q428(((sq_a - sq_b) >>> FRAC) + c_re);
         zb = clip_q428((prod_ab >>> (FRAC - 1)) + c_im);
         n++;
      end
      return n[15:0];
   endfunction

   // Pixel driver: hold the request while busy, predict on each transfer
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            count_q.push_back(escape_count(req_col, req_row));
         end
         if (pixel_q.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
            next_px = pixel_q.pop_front();
            start   <= 1'b1;
            req_col <= next_px.col;
            req_row <= next_px.row;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Count monitor: match each strobed count against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (count_q.size() == 0) begin
            $error("iterations: expected none, got %0d", rsp_iterations);
            errors++;
         end else begin
            want_count = count_q.pop_front();
            if (rsp_iterations !== want_count) begin
               $error("iterations: expected %0d, got %0d", want_count, rsp_iterations);
               errors++;
            end
         end
      end
   end

   // Register write over the configuration port; mirror it into the view
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (mbe_pkg::reg_idx_type'(idx))
         mbe_pkg::REG_LEFT:     view.left_edge   = data;
         mbe_pkg::REG_BOTTOM:   view.bottom_edge = data;
         mbe_pkg::REG_STEP_X:   view.step_x      = data[30:0];
         mbe_pkg::REG_STEP_Y:   view.step_y      = data[30:0];
         mbe_pkg::REG_MAX_ITER: view.max_iter    = data[15:0];
         default: ;
      endcase
   endtask

   task automatic load_view(input logic [31:0] left, input logic [31:0] bottom,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [15:0] limit);
      csr_write(mbe_pkg::REG_LEFT, left);
      csr_write(mbe_pkg::REG_BOTTOM, bottom);
      csr_write(mbe_pkg::REG_STEP_X, sx);
      csr_write(mbe_pkg::REG_STEP_Y, sy);
      csr_write(mbe_pkg::REG_MAX_ITER, {16'h0000, limit});
   endtask

   // Hold off until every issued pixel has come back and the unit is idle;
   // look between edges so the driver's updates have settled
   task automatic drain();
      while (pixel_q.size() != 0 || start || count_q.size() != 0 || busy)
         @(negedge clock);
   endtask

   // Random viewport: mostly framing the set, some deep zooms, some noise
   task automatic random_view();
      int unsigned pick;
      logic [31:0] left, bottom, sx, sy;
      logic [15:0] limit;
      pick = $urandom_range(99);
      if (pick < 60) begin
         left   = -int'($urandom_range(805306368, 402653184));
         bottom = -int'($urandom_range(671088640, 402653184));
         sx     = $urandom_range(1 << 19, 1 << 17);
         sy     = $urandom_range(1 << 19, 1 << 17);
      end else if (pick < 85) begin
         left   = int'($urandom_range(671088640, 0)) - 536870912;
         bottom = int'($urandom_range(603979776, 0)) - 335544320;
         sx     = $urandom_range(1 << 14, 1);
         sy     = $urandom_range(1 << 14, 1);
      end else begin
         left   = $urandom;
         bottom = $urandom;
         sx     = $urandom;
         sy     = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
         limit = 16'($urandom_range(64, 1));
      end else if (pick < 95) begin
         limit = 16'($urandom_range(300, 65));
      end else begin
         limit = mbe_pkg::MAX_ITER_RESET;
      end
      load_view(left, bottom, sx, sy, limit);
   endtask

   // Stimulus
   initial begin
      view.left_edge   = mbe_pkg::LEFT_RESET;
      view.bottom_edge = mbe_pkg::BOTTOM_RESET;
      view.step_x      = mbe_pkg::STEP_X_RESET;
      view.step_y      = mbe_pkg::STEP_Y_RESET;
      view.max_iter    = mbe_pkg::MAX_ITER_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset viewport: corners, points inside, the c = -2 boundary, saturation
      pixel_q.push_back('{12'd0, 12'd0});
      pixel_q.push_back('{12'd4095, 12'd4095});
      pixel_q.push_back('{12'd512, 12'd512});
      pixel_q.push_back('{12'd256, 12'd512});
      pixel_q.push_back('{12'd448, 12'd512});
      pixel_q.push_back('{12'd576, 12'd512});
      pixel_q.push_back('{12'd600, 12'd512});
      pixel_q.push_back('{12'd0, 12'd512});
      pixel_q.push_back('{12'd512, 12'd0});
      pixel_q.push_back('{12'd4095, 12'd512});
      pixel_q.push_back('{12'd512, 12'd4095});
      pixel_q.push_back('{12'd2730, 12'd1365});
      pixel_q.push_back('{12'd1365, 12'd2730});
      pixel_q.push_back('{12'd0, 12'd4095});
      pixel_q.push_back('{12'd4095, 12'd0});
      drain();

      // Writes to unused register slots must leave the viewport alone
      for (int i = REG_UNUSED_FIRST; i <= REG_UNUSED_LAST; i++)
         csr_write(i[2:0], $urandom);

      // Zero limit: no iteration runs
      csr_write(mbe_pkg::REG_MAX_ITER, 32'd0);
      pixel_q.push_back('{12'd512, 12'd512});
      pixel_q.push_back('{12'd0, 12'd0});
      drain();

      // Limit of one
      csr_write(mbe_pkg::REG_MAX_ITER, 32'd1);
      pixel_q.push_back('{12'd512, 12'd512});
      pixel_q.push_back('{12'd4095, 12'd4095});
      drain();

      // Extreme edges and steps: coordinates clip at both ends
      load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 16'd255);
      pixel_q.push_back('{12'd0, 12'd0});
      pixel_q.push_back('{12'd4095, 12'd4095});
      pixel_q.push_back('{12'd4095, 12'd0});
      drain();

      // Origin with the largest limit: the count runs to the end
      load_view(32'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF);
      pixel_q.push_back('{12'd4095, 12'd4095});
      drain();

      // Random viewports, one pass with the sender never pausing
      for (int p = 0; p < PHASES; p++) begin
         random_view();
         quiet = (p == QUIET_PASS);
         for (int k = 0; k < PHASE_PIX; k++)
            pixel_q.push_back('{12'($urandom_range(4095)), 12'($urandom_range(4095))});
         drain();
      end
      quiet = 1'b0;

      // Catch any stray strobe before finishing
      repeat (50) @(posedge clock);
      if (errors == 0 && count_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #100ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
